/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs across reset.
`define CHK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/scfq_pkg.sv */
// Types and codes shared by the searchable FIFO queue files.
package scfq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_SEARCH,
    CMD_EDIT,
    CMD_INFO,
    CMD_VIEW
  } cmd_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_BADPOS  = 3'd3;
  localparam logic [2:0] ST_NOMATCH = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  localparam int POS_W = 5;
  localparam int TOTAL_W = 36;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] operand_value;
    logic [POS_W-1:0]   position_in;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [POS_W-1:0]        position;
    logic signed [31:0]      element_value;
    logic signed [TOTAL_W-1:0] total_sum;
    logic signed [31:0]      average;
    logic signed [31:0]      maximum;
    logic signed [31:0]      minimum;
    logic [POS_W-1:0]        count;
    logic                    last;
  } rsp_t;

endpackage

/* rtl/core/scfq_store.sv */
// Item memory: one write port, one read port with registered read data.
module scfq_store #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [31:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/scfq_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
module scfq_div #(
  parameter int SUM_W = 36,
  parameter int CNT_W = 5,
  localparam int STEP_W = $clog2(SUM_W + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    busy,
  output logic signed [31:0]      quotient
);

  logic [SUM_W-1:0]  shreg;   // dividend magnitude, shifted out as quotient shifts in
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvsr;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic [CNT_W:0]    trial;
  logic              qbit;

  assign trial = {rem, shreg[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      neg   <= dividend[SUM_W-1];
      shreg <= dividend[SUM_W-1] ? -dividend : dividend;
      rem   <= '0;
      dvsr  <= divisor;
      step  <= STEP_W'(SUM_W);
    end else if (busy) begin
      rem   <= qbit ? CNT_W'(trial - {1'b0, dvsr}) : CNT_W'(trial);
      shreg <= {shreg[SUM_W-2:0], qbit};
      step  <= step - STEP_W'(1);
      if (step == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = 32'(neg ? -shreg : shreg);

endmodule

/* rtl/core/searchable_fifo_queue_core.sv */
// Searchable FIFO queue: sequencer, circular item store and shared walk unit.
//
// Request channel req (req_valid / req_stall) carries cmd, operand_value and
// position_in; response channel rsp (rsp_valid / rsp_stall) carries one or
// more results per command, the final one marked by last. An item is taken
// when valid is high and stall is low. The block holds one command at a time:
// req_stall stays high from acceptance until the command's last result has
// been loaded into the output register.
// Push, pop and rejected commands: the result is loaded from the EXEC state.
// Edit reads its item through READ and EVAL, then writes it in EVAL. Search
// and view walk the stored items through the single memory read port, one
// READ and EVAL per item. Info walks the same way with one add and two
// compares (max and min) per item, then runs the bit-serial divider for the
// average. Unused cmd codes return no result and free the block.
// Reset empties the queue (count and head cleared) and drops any pending
// result; memory contents are not cleared, entries are only read once pushed.
// A stalled result holds in the output register and the next one waits.
module searchable_fifo_queue_core
  import scfq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = 32 + $clog2(DEPTH) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_EVAL,
    S_FINISH,
    S_DIV
  } state_t;

  state_t             state;
  logic [2:0]         cmd_q;
  logic signed [31:0] opnd;
  logic [POS_W-1:0]   pos_q;
  logic [CNT_W-1:0]   count;
  logic [AW-1:0]      head;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   pend_pos;
  logic               have_pend;
  logic signed [SUM_W-1:0] sum_acc;
  logic signed [31:0] mx;
  logic signed [31:0] mn;

  logic               slot_free;
  logic               last_item;
  logic [CNT_W-1:0]   idx_inc;
  logic signed [SUM_W-1:0] sum_next;
  logic               pos_bad;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] rdata;

  logic               div_start;
  logic               div_busy;
  logic signed [31:0] quotient;

  // queue position (0 = head) to memory entry
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd,
                                         input logic [CNT_W-1:0] ix);
    logic [AW:0] s;
    s = {1'b0, hd} + (AW+1)'(ix);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic rsp_t make_rsp(input logic [2:0] st,
                                    input logic [CNT_W-1:0] p,
                                    input logic signed [31:0] elem,
                                    input logic signed [SUM_W-1:0] sm,
                                    input logic signed [31:0] avg,
                                    input logic signed [31:0] hi,
                                    input logic signed [31:0] lo,
                                    input logic [CNT_W-1:0] cnt,
                                    input logic lst);
    rsp_t r;
    r.status        = st;
    r.position      = POS_W'(p);
    r.element_value = elem;
    r.total_sum     = TOTAL_W'(sm);
    r.average       = avg;
    r.maximum       = hi;
    r.minimum       = lo;
    r.count         = POS_W'(cnt);
    r.last          = lst;
    return r;
  endfunction

  assign req_stall = (state != S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign idx_inc   = idx + CNT_W'(1);
  assign last_item = (idx_inc == count);
  assign sum_next  = sum_acc + SUM_W'(rdata);
  assign pos_bad   = (pos_q == '0) || (int'(pos_q) > int'(count));

  assign mem_raddr = phys(head, idx);
  assign div_start = (state == S_EVAL) && (cmd_q == CMD_INFO) && last_item;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = phys(head, count);
    if (state == S_EXEC && slot_free && cmd_q == CMD_PUSH && count != CNT_W'(DEPTH)) begin
      mem_we = 1'b1;
    end else if (state == S_EVAL && slot_free && cmd_q == CMD_EDIT) begin
      mem_we    = 1'b1;
      mem_waddr = mem_raddr;
    end
  end

  scfq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (opnd),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  scfq_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q <= req.cmd;
            opnd  <= req.operand_value;
            pos_q <= req.position_in;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            state     <= S_IDLE;
            idx       <= '0;
            have_pend <= 1'b0;
            sum_acc   <= '0;
            case (cmd_q)
              CMD_PUSH: begin
                rsp_valid <= 1'b1;
                if (count == CNT_W'(DEPTH)) begin
                  rsp <= make_rsp(ST_OVER, '0, '0, '0, '0, '0, '0, count, 1'b1);
                end else begin
                  count <= count + CNT_W'(1);
                  rsp <= make_rsp(ST_OK, '0, '0, '0, '0, '0, '0,
                                  count + CNT_W'(1), 1'b1);
                end
              end
              CMD_POP: begin
                rsp_valid <= 1'b1;
                if (count == '0) begin
                  rsp <= make_rsp(ST_UNDER, '0, '0, '0, '0, '0, '0, count, 1'b1);
                end else begin
                  count <= count - CNT_W'(1);
                  head  <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
                  rsp <= make_rsp(ST_OK, '0, '0, '0, '0, '0, '0,
                                  count - CNT_W'(1), 1'b1);
                end
              end
              CMD_EDIT: begin
                if (pos_bad) begin
                  rsp_valid <= 1'b1;
                  rsp <= make_rsp(ST_BADPOS, '0, '0, '0, '0, '0, '0, count, 1'b1);
                end else begin
                  idx   <= CNT_W'(pos_q - POS_W'(1));
                  state <= S_READ;
                end
              end
              CMD_SEARCH, CMD_INFO, CMD_VIEW: begin
                if (count == '0) begin
                  rsp_valid <= 1'b1;
                  rsp <= make_rsp((cmd_q == CMD_SEARCH) ? ST_NOMATCH : ST_EMPTY,
                                  '0, '0, '0, '0, '0, '0, count, 1'b1);
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          case (cmd_q)
            CMD_EDIT: begin
              if (slot_free) begin
                rsp_valid <= 1'b1;
                rsp <= make_rsp(ST_OK, idx_inc, rdata, '0, '0, '0, '0, count, 1'b1);
                state <= S_IDLE;
              end
            end
            CMD_VIEW: begin
              if (slot_free) begin
                rsp_valid <= 1'b1;
                rsp <= make_rsp(ST_OK, idx_inc, rdata, '0, '0, '0, '0, count, last_item);
                idx   <= idx_inc;
                state <= last_item ? S_IDLE : S_READ;
              end
            end
            CMD_SEARCH: begin
              // a match is held back one step so the final one can carry last
              if (rdata != opnd) begin
                idx   <= idx_inc;
                state <= last_item ? S_FINISH : S_READ;
              end else if (!have_pend || slot_free) begin
                if (have_pend) begin
                  rsp_valid <= 1'b1;
                  rsp <= make_rsp(ST_OK, pend_pos, '0, '0, '0, '0, '0, count, 1'b0);
                end
                have_pend <= 1'b1;
                pend_pos  <= idx_inc;
                idx       <= idx_inc;
                state     <= last_item ? S_FINISH : S_READ;
              end
            end
            default: begin
              sum_acc <= sum_next;
              if (idx == '0 || rdata > mx) begin
                mx <= rdata;
              end
              if (idx == '0 || rdata < mn) begin
                mn <= rdata;
              end
              idx   <= idx_inc;
              state <= last_item ? S_DIV : S_READ;
            end
          endcase
        end
        S_FINISH: begin
          if (slot_free) begin
            rsp_valid <= 1'b1;
            if (have_pend) begin
              rsp <= make_rsp(ST_OK, pend_pos, '0, '0, '0, '0, '0, count, 1'b1);
            end else begin
              rsp <= make_rsp(ST_NOMATCH, '0, '0, '0, '0, '0, '0, count, 1'b1);
            end
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (!div_busy && slot_free) begin
            rsp_valid <= 1'b1;
            rsp <= make_rsp(ST_OK, '0, '0, sum_acc, quotient, mx, mn, count, 1'b1);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/scfq_checker.sv */
// Port-level checks for the searchable FIFO queue, bound to the top level.
`include "assert_macros.svh"

module scfq_checker
  import scfq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  `CHK_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled result changed")
  `CHK_ASSERT_RST(a_reset_idle, rst |=> !rsp_valid && !req_stall, "block not idle after reset")
  `CHK_ASSERT(a_one_cmd, req_valid && !req_stall |=> req_stall, "second item taken while busy")
  `CHK_ASSERT(a_run_ok, rsp_valid && !rsp.last |-> rsp.status == ST_OK, "non-final result not ok")
  `CHK_ASSERT(a_empty_cnt, rsp_valid && (rsp.status == ST_UNDER || rsp.status == ST_EMPTY) |-> rsp.count == '0, "empty status with items held")

endmodule

bind searchable_fifo_queue_core scfq_checker u_scfq_checker (.*);
